// ===== rtl/cdet_pkg.sv =====
// Shared types, widths and a helper function for the cofactor determinant unit.
// No dependencies; every other file of the block but cdet_ram uses this package.
package cdet_pkg;

  localparam int ENTRY_W       = 16;  // Q8.8 matrix entry
  localparam int AMAG_W        = 16;  // entry magnitude, 32768 still fits unsigned
  localparam int ORD_W         = 3;   // matrix order register
  localparam int LIN_W         = 2 * ORD_W;
  localparam int DET_W         = 64;
  localparam int LIMB_W        = 32;  // multiplier slice of the wide operand
  localparam int MAX_ORDER_DEF = 4;

  localparam logic [ORD_W-1:0] SIZE_RESET = ORD_W'(3);
  localparam logic [DET_W-1:0] DET_MAX    = {1'b0, {(DET_W-1){1'b1}}};
  localparam logic [DET_W-1:0] DET_MIN    = {1'b1, {(DET_W-1){1'b0}}};

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_PICK,
    SEQ_FETCH,
    SEQ_MUL,
    SEQ_STORE,
    SEQ_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    MAC_IDLE,
    MAC_MUL,
    MAC_ADD
  } mac_phase_t;

  typedef struct packed {
    logic start;  // load operand and magnitude, begin limb loop
    logic sub;    // subtract the product instead of adding it
    logic clear;  // zero the accumulator
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;   // accumulate happens at the coming edge
  } mac_stat_t;

  typedef struct packed {
    logic             valid;
    logic [DET_W-1:0] det;
    logic             ovf;
  } res_t;

  // Accumulator width: |det| <= n! * 2^(15n), plus sign, at least 65 bits so
  // saturation can be detected, rounded up to whole limbs.
  function automatic int acc_width(int max_order);
    int f;
    int bits;
    f = 1;
    for (int i = 2; i <= max_order; i++) begin
      f = f * i;
    end
    bits = 16 * max_order + $clog2(f + 1) + 1;
    if (bits < DET_W + 1) begin
      bits = DET_W + 1;
    end
    return ((bits + LIMB_W - 1) / LIMB_W) * LIMB_W;
  endfunction

endpackage

// ===== rtl/matrix_determinant_cofactor_unit.sv =====
// Determinant by cofactor expansion over a streamed square matrix.
// Top level; depends on cdet_pkg, cdet_ram, cdet_mac and cdet_seq.
//
// Usage:
//   Write the matrix order (1..MAX_ORDER; 0 acts as 1, larger acts as MAX_ORDER)
//   on cfg_we/cfg_wdata while the block is idle. Reset sets it to 3.
//   Stream entries row-major on the s_axis channel, one signed Q8.8 entry per
//   transaction, one per cycle into the entry store while s_axis_tready is high.
//   The transaction that completes n*n entries starts the expansion; s_axis_tready
//   drops until the result has moved into the output register.
//   The expansion builds every minor of the bottom rows, one column subset at a
//   time, and keeps them in the minor store. Each term passes the L = ACC_W/32
//   limbs of the wide operand through the 32x16 multiplier, which sets the rate.
//   The m_axis channel carries the determinant (8n fraction bits) saturated to
//   64 bits, with the overflow flag on tuser. The output register holds while
//   m_axis_tready is low; loading of the next matrix continues meanwhile, and a
//   finished expansion waits for the register to free up.
//   Reset clears the load count, the sequencer and the output valid; the entry
//   and minor stores are not cleared.
module matrix_determinant_cofactor_unit #(
  parameter int MAX_ORDER = cdet_pkg::MAX_ORDER_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cdet_pkg::ORD_W-1:0]   cfg_wdata,     // matrix_size
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [cdet_pkg::ENTRY_W-1:0] s_axis_tdata,  // [15:0] entry_value
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [cdet_pkg::DET_W-1:0]   m_axis_tdata,  // [63:0] determinant
  output logic                         m_axis_tuser   // [0] overflow
);
  import cdet_pkg::*;

  localparam int DEPTH       = MAX_ORDER * MAX_ORDER;
  localparam int EA_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MINOR_DEPTH = 1 << MAX_ORDER;
  localparam int ACC_W       = acc_width(MAX_ORDER);
  localparam int CMP_W       = LIN_W + 1;

  logic [ORD_W-1:0]   matrix_size;
  logic [EA_W-1:0]    load_count;
  logic [ORD_W-1:0]   order;
  logic [LIN_W-1:0]   need;
  logic               accept;
  logic               complete;
  logic               start;
  logic               seq_busy;
  logic               out_free;

  logic [EA_W-1:0]    entry_raddr;
  logic [ENTRY_W-1:0] entry_rdata;
  logic [MAX_ORDER-1:0] minor_raddr;
  logic [MAX_ORDER-1:0] minor_waddr;
  logic [ACC_W-1:0]   minor_rdata;
  logic               minor_we;
  logic [ACC_W-1:0]   operand;
  logic [AMAG_W-1:0]  amag;
  logic [ACC_W-1:0]   acc;
  mac_ctrl_t          mac_ctrl;
  mac_stat_t          mac_stat;
  res_t               res;

  // Clamp the order register to the supported range.
  always_comb begin
    if (matrix_size == '0) begin
      order = ORD_W'(1);
    end else if (matrix_size > ORD_W'(MAX_ORDER)) begin
      order = ORD_W'(MAX_ORDER);
    end else begin
      order = matrix_size;
    end
  end

  assign need          = LIN_W'(order) * LIN_W'(order);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign complete      = (CMP_W'(load_count) + 1'b1) >= CMP_W'(need);
  assign start         = accept && complete;
  assign s_axis_tready = ~seq_busy;
  assign out_free      = ~m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (cfg_we) begin
      matrix_size <= cfg_wdata;
    end
  end

  // Count entries of the current matrix; drop back to zero on the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (accept) begin
      load_count <= complete ? '0 : load_count + 1'b1;
    end
  end

  // Output register: load on a finished expansion, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_axis_tdata <= res.det;
      m_axis_tuser <= res.ovf;
    end
  end

  cdet_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH),
    .AW    (EA_W)
  ) u_entry_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (load_count),
    .wdata (s_axis_tdata),
    .raddr (entry_raddr),
    .rdata (entry_rdata)
  );

  // Minor store: a subset is written in its STORE cycle and read no earlier
  // than the following cycle, so no forwarding is needed.
  cdet_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MINOR_DEPTH),
    .AW    (MAX_ORDER)
  ) u_minor_ram (
    .clk   (clk),
    .we    (minor_we),
    .waddr (minor_waddr),
    .wdata (acc),
    .raddr (minor_raddr),
    .rdata (minor_rdata)
  );

  cdet_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (mac_ctrl),
    .operand (operand),
    .amag    (amag),
    .stat    (mac_stat),
    .acc     (acc)
  );

  cdet_seq #(
    .MAX_ORDER (MAX_ORDER),
    .ACC_W     (ACC_W),
    .EA_W      (EA_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .order       (order),
    .out_free    (out_free),
    .busy        (seq_busy),
    .entry_raddr (entry_raddr),
    .entry_rdata (entry_rdata),
    .minor_raddr (minor_raddr),
    .minor_rdata (minor_rdata),
    .minor_we    (minor_we),
    .minor_waddr (minor_waddr),
    .operand     (operand),
    .amag        (amag),
    .mac_ctrl    (mac_ctrl),
    .mac_stat    (mac_stat),
    .acc         (acc),
    .res         (res)
  );

`ifndef SYNTHESIS
  // The last entry of a matrix must close the input.
  a_close_after_last: assert property (@(posedge clk) disable iff (rst)
    start |=> !s_axis_tready)
    else $error("input still open after the last entry of a matrix");

  // While expanding, the load count must already be back at zero.
  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    seq_busy |-> (load_count == '0))
    else $error("load count nonzero during expansion");

  // A result may only enter the output register when it is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote a pending output transaction");
`endif

endmodule

// ===== rtl/cdet_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the entry store and for the minor store; no package dependency.
module cdet_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cdet_mac.sv =====
// Limb-serial multiply-accumulate: wide two's complement operand times a
// 16-bit magnitude, one 32-bit limb per cycle, then add or subtract. Uses cdet_pkg.
module cdet_mac #(
  parameter int ACC_W = 96
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cdet_pkg::mac_ctrl_t          ctrl,
  input  logic [ACC_W-1:0]             operand,
  input  logic [cdet_pkg::AMAG_W-1:0]  amag,
  output cdet_pkg::mac_stat_t          stat,
  output logic [ACC_W-1:0]             acc
);
  import cdet_pkg::*;

  localparam int LIMBS = ACC_W / LIMB_W;
  localparam int LC_W  = (LIMBS > 1) ? $clog2(LIMBS) : 1;
  localparam int T_W   = LIMB_W + AMAG_W;

  mac_phase_t        phase, phase_next;
  logic [ACC_W-1:0]  opnd;
  logic [ACC_W-1:0]  prod;
  logic [AMAG_W-1:0] mag;
  logic [AMAG_W-1:0] carry;
  logic [LC_W-1:0]   limb;
  logic              sub_q;
  logic [T_W-1:0]    t;
  logic              last_limb;

  assign t         = T_W'(opnd[LIMB_W-1:0]) * T_W'(mag) + T_W'(carry);
  assign last_limb = (limb == LC_W'(LIMBS - 1));

  always_comb begin
    phase_next = phase;
    case (phase)
      MAC_IDLE: if (ctrl.start) phase_next = MAC_MUL;
      MAC_MUL:  if (last_limb) phase_next = MAC_ADD;
      MAC_ADD:  phase_next = MAC_IDLE;
      default:  phase_next = MAC_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = (phase != MAC_IDLE);
    stat.done = (phase == MAC_ADD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= MAC_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // Shift operand limbs out at the bottom, product limbs in at the top.
  always_ff @(posedge clk) begin
    if (phase == MAC_IDLE && ctrl.start) begin
      opnd  <= operand;
      mag   <= amag;
      sub_q <= ctrl.sub;
      carry <= '0;
      limb  <= '0;
    end else if (phase == MAC_MUL) begin
      opnd  <= {{LIMB_W{1'b0}}, opnd[ACC_W-1:LIMB_W]};
      prod  <= {t[LIMB_W-1:0], prod[ACC_W-1:LIMB_W]};
      carry <= t[T_W-1:LIMB_W];
      limb  <= limb + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (phase == MAC_ADD) begin
      acc <= acc + (sub_q ? ~prod : prod) + ACC_W'(sub_q);
    end
  end

endmodule

// ===== rtl/cdet_seq.sv =====
// Cofactor sequencer: walks column subsets in increasing order, reads entries
// and stored minors, drives the MAC and writes each minor back. Uses cdet_pkg.
module cdet_seq #(
  parameter int MAX_ORDER = 4,
  parameter int ACC_W     = 96,
  parameter int EA_W      = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cdet_pkg::ORD_W-1:0]    order,
  input  logic                          out_free,
  output logic                          busy,
  output logic [EA_W-1:0]               entry_raddr,
  input  logic [cdet_pkg::ENTRY_W-1:0]  entry_rdata,
  output logic [MAX_ORDER-1:0]          minor_raddr,
  input  logic [ACC_W-1:0]              minor_rdata,
  output logic                          minor_we,
  output logic [MAX_ORDER-1:0]          minor_waddr,
  output logic [ACC_W-1:0]              operand,
  output logic [cdet_pkg::AMAG_W-1:0]   amag,
  output cdet_pkg::mac_ctrl_t           mac_ctrl,
  input  cdet_pkg::mac_stat_t           mac_stat,
  input  logic [ACC_W-1:0]              acc,
  output cdet_pkg::res_t                res
);
  import cdet_pkg::*;

  localparam int COL_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  seq_state_t           state, state_next;
  logic [ORD_W-1:0]     order_q;
  logic [MAX_ORDER-1:0] mask;
  logic [MAX_ORDER-1:0] rem;
  logic                 parity;
  logic                 sub_zero;

  logic [MAX_ORDER-1:0] low_bit;
  logic [MAX_ORDER-1:0] sub_mask;
  logic [MAX_ORDER-1:0] full;
  logic [COL_W-1:0]     low_idx;
  logic [ORD_W-1:0]     cnt;
  logic [ORD_W-1:0]     row;
  logic [LIN_W-1:0]     lin;
  logic [ACC_W-DET_W:0] top_bits;
  logic                 fits;

  always_comb begin
    low_bit = rem & (~rem + 1'b1);
    low_idx = '0;
    cnt     = '0;
    for (int i = 0; i < MAX_ORDER; i++) begin
      if (low_bit[i]) low_idx = COL_W'(i);
      cnt = cnt + ORD_W'(mask[i]);
    end
  end

  // Row of the expansion follows from how many columns the subset holds.
  assign row      = order_q - cnt;
  assign lin      = LIN_W'(row) * LIN_W'(order_q) + LIN_W'(low_idx);
  assign sub_mask = mask & ~low_bit;
  assign full     = ~({MAX_ORDER{1'b1}} << order_q);
  assign top_bits = acc[ACC_W-1:DET_W-1];
  assign fits     = (&top_bits) | ~(|top_bits);

  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE:  if (start) state_next = SEQ_PICK;
      SEQ_PICK:  state_next = (rem == '0) ? SEQ_STORE : SEQ_FETCH;
      SEQ_FETCH: state_next = SEQ_MUL;
      SEQ_MUL:   if (mac_stat.done) state_next = SEQ_PICK;
      SEQ_STORE: state_next = (mask == full) ? SEQ_DONE : SEQ_PICK;
      SEQ_DONE:  if (out_free) state_next = SEQ_IDLE;
      default:   state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    busy           = (state != SEQ_IDLE);
    entry_raddr    = lin[EA_W-1:0];
    minor_raddr    = sub_mask;
    minor_we       = (state == SEQ_STORE);
    minor_waddr    = mask;
    operand        = sub_zero ? ACC_W'(1) : minor_rdata;
    amag           = entry_rdata[ENTRY_W-1] ? (~entry_rdata + 1'b1) : entry_rdata;
    mac_ctrl.start = (state == SEQ_FETCH);
    mac_ctrl.sub   = parity ^ entry_rdata[ENTRY_W-1];
    mac_ctrl.clear = (state == SEQ_IDLE && start) || (state == SEQ_STORE && mask != full);
    res.valid      = (state == SEQ_DONE) && out_free;
    res.det        = fits ? acc[DET_W-1:0] : (acc[ACC_W-1] ? DET_MIN : DET_MAX);
    res.ovf        = ~fits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SEQ_IDLE: begin
        if (start) begin
          order_q <= order;
          mask    <= MAX_ORDER'(1);
          rem     <= MAX_ORDER'(1);
          parity  <= 1'b0;
        end
      end
      SEQ_PICK: begin
        if (rem != '0) begin
          rem      <= rem & ~low_bit;
          sub_zero <= (sub_mask == '0);
        end
      end
      SEQ_FETCH: begin
        parity <= ~parity;
      end
      SEQ_STORE: begin
        if (mask != full) begin
          mask   <= mask + 1'b1;
          rem    <= mask + 1'b1;
          parity <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
